### rtl/tal_pkg.sv
`timescale 1ns / 1ps
package tal_pkg;

  // table depth and derived widths
  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int KEY_W = 64;
  localparam int OUT_CNT_W = 5;

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_AUTHFAIL = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_REPLAY   = 2'd3;

  // write port of the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] id;
    logic [KEY_W-1:0] nonce;
  } tal_wr_t;

  // finished result handed to the output stage
  typedef struct packed {
    logic                 valid;
    logic [1:0]           status;
    logic                 found;
    logic [OUT_CNT_W-1:0] count;
    logic                 loaded;
  } tal_res_t;

  // low bits of the fill count as reported on the result
  function automatic logic [OUT_CNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] w;
    w = {{OUT_CNT_W{1'b0}}, c};
    return w[OUT_CNT_W-1:0];
  endfunction

endpackage

### rtl/target_allowlist_with_replay_guard_core.sv
`timescale 1ns / 1ps
// Allow-list of device identifiers with a nonce replay guard.
// Input channel (in_*): one request per item, operation 0 adds an
// identifier/nonce pair, 1 checks an identifier, 2 clears the table.
// The add carries the authentication result as in_auth_passed.
// Result channel (out_*): exactly one result per request, in order, with
// status, id_found, the entry count after the request and a loaded flag.
// Requests that need no search (clear, unused codes, failed authentication,
// full table) go straight to the done state; a search ends early on a match.
// The single 64-bit comparator walks the entry store one entry per cycle, so
// one request is in work at a time and in_stall stays high until its result
// is in the output register. The output register lets the next request be
// accepted while a result waits. When out_stall is high the result holds,
// and while the output register is full a finished search waits inside the
// block.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; entry contents are not cleared, only the fill count.
module target_allowlist_with_replay_guard_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_device_id,
  input  logic [63:0] in_record_nonce,
  input  logic        in_auth_passed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_id_found,
  output logic [4:0]  out_entry_count,
  output logic        out_loaded
);
  import tal_pkg::*;

  tal_wr_t          wr;
  tal_res_t         res;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_id;
  logic [KEY_W-1:0] rd_nonce;
  logic             res_take;

  logic       out_valid_r;
  logic [1:0] status_r;
  logic       found_r;
  logic [4:0] count_r;
  logic       loaded_r;

  tal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req_op    (in_operation),
    .req_id    (in_device_id),
    .req_nonce (in_record_nonce),
    .req_auth  (in_auth_passed),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd_id     (rd_id),
    .rd_nonce  (rd_nonce),
    .res       (res),
    .res_take  (res_take)
  );

  tal_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_id    (rd_id),
    .rd_nonce (rd_nonce)
  );

  // output register loads when empty or being drained
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status_r <= res.status;
      found_r  <= res.found;
      count_r  <= res.count;
      loaded_r <= res.loaded;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_id_found    = found_r;
  assign out_entry_count = count_r;
  assign out_loaded      = loaded_r;

endmodule

### rtl/tal_store.sv
`timescale 1ns / 1ps
module tal_store (
  input  logic                    clk,
  input  tal_pkg::tal_wr_t        wr,
  input  logic [tal_pkg::IDX_W-1:0] rd_addr,
  output logic [tal_pkg::KEY_W-1:0] rd_id,
  output logic [tal_pkg::KEY_W-1:0] rd_nonce
);
  import tal_pkg::*;

  logic [KEY_W-1:0] ids_mem    [MAX_ENTRIES];
  logic [KEY_W-1:0] nonces_mem [MAX_ENTRIES];
  logic [KEY_W-1:0] rd_id_r;
  logic [KEY_W-1:0] rd_nonce_r;

  // append port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ids_mem[wr.addr]    <= wr.id;
      nonces_mem[wr.addr] <= wr.nonce;
    end
  end

  // registered read, one entry per cycle
  always_ff @(posedge clk) begin
    rd_id_r    <= ids_mem[rd_addr];
    rd_nonce_r <= nonces_mem[rd_addr];
  end

  assign rd_id    = rd_id_r;
  assign rd_nonce = rd_nonce_r;

endmodule

### rtl/tal_ctrl.sv
`timescale 1ns / 1ps
module tal_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [1:0]                req_op,
  input  logic [tal_pkg::KEY_W-1:0] req_id,
  input  logic [tal_pkg::KEY_W-1:0] req_nonce,
  input  logic                      req_auth,
  output tal_pkg::tal_wr_t          wr,
  output logic [tal_pkg::IDX_W-1:0] rd_addr,
  input  logic [tal_pkg::KEY_W-1:0] rd_id,
  input  logic [tal_pkg::KEY_W-1:0] rd_nonce,
  output tal_pkg::tal_res_t         res,
  input  logic                      res_take
);
  import tal_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic             is_add_r, is_add_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] id_r, id_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             found_r, found_nxt;
  logic [KEY_W-1:0] cmp_data;
  logic             hit;

  // shared comparator: stored nonce for add, stored identifier for check
  assign cmp_data = is_add_r ? rd_nonce : rd_id;
  assign hit      = cmp_v_r && (cmp_data == key_r);

  assign rd_addr   = idx_r[IDX_W-1:0];
  assign req_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    cmp_v_nxt  = 1'b0;
    is_add_nxt = is_add_r;
    key_nxt    = key_r;
    id_nxt     = id_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    wr.en      = 1'b0;
    wr.addr    = count_r[IDX_W-1:0];
    wr.id      = id_r;
    wr.nonce   = key_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          id_nxt     = req_id;
          unique case (req_op)
            OP_ADD: begin
              is_add_nxt = 1'b1;
              key_nxt    = req_nonce;
              if (!req_auth) begin
                status_nxt = ST_AUTHFAIL;
                state_nxt  = S_DONE;
              end else if (count_r >= CNT_W'(MAX_ENTRIES)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_CHECK: begin
              is_add_nxt = 1'b0;
              key_nxt    = req_id;
              state_nxt  = S_SCAN;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        priority if (hit) begin
          if (is_add_r) begin
            status_nxt = ST_REPLAY;
          end else begin
            found_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (idx_r < count_r) begin
          idx_nxt   = idx_r + 1'b1;
          cmp_v_nxt = 1'b1;
        end else begin
          // every stored entry compared without a match
          if (is_add_r) begin
            wr.en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result view
  always_comb begin
    res.valid  = (state_r == S_DONE);
    res.status = status_r;
    res.found  = found_r;
    res.count  = count_out(count_r);
    res.loaded = (count_r != '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    is_add_r <= is_add_nxt;
    key_r    <= key_nxt;
    id_r     <= id_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

endmodule
